/* sv/crmr_pkg.sv */
package crmr_pkg;

  // configuration of the id layout and storage
  localparam int SOURCES      = 16;
  localparam int SEQ_SHIFT    = 7;
  localparam int SOURCE_SHIFT = 0;
  localparam int SOURCE_BITS  = 4;
  localparam int MAX_WORDS    = 32;

  // field widths
  localparam int FID_W   = 29;
  localparam int CNT_W   = 4;
  localparam int DATA_W  = 64;
  localparam int ID_W    = 22;
  localparam int LEFT_W  = 6;
  localparam int LEN_W   = 7;
  localparam int WORDS_W = 6;
  localparam int IDX_W   = $clog2(MAX_WORDS);
  localparam int SRC_W   = SOURCE_BITS;
  localparam int DEPTH   = SOURCES * MAX_WORDS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // id bit that is clear on the first frame of a message
  localparam int FIRST_BIT = LEFT_W;

  // completed message handed from front to back
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [ID_W-1:0]  msg_id;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // back end finished reading a source's words
  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] src;
  } release_t;

  // word address of a slot entry
  function automatic logic [ADDR_W-1:0] word_addr(logic [SRC_W-1:0] src,
                                                  logic [IDX_W-1:0] idx);
    return ADDR_W'(int'(src) * MAX_WORDS + int'(idx));
  endfunction

endpackage

/* sv/crmr_ram.sv */
module crmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/crmr_front.sv */
module crmr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [crmr_pkg::FID_W-1:0]      frame_id_i,
  input  logic [crmr_pkg::CNT_W-1:0]      byte_count_i,
  input  logic [crmr_pkg::DATA_W-1:0]     frame_data_i,
  input  logic                            q_full_i,
  output crmr_pkg::push_t                 push_o,
  input  crmr_pkg::release_t              release_i,
  output logic                            we_o,
  output logic [crmr_pkg::ADDR_W-1:0]     waddr_o,
  output logic [crmr_pkg::DATA_W-1:0]     wdata_o
);

  // held frame
  logic                        held_q;
  logic [crmr_pkg::FID_W-1:0]  fid_q;
  logic [crmr_pkg::CNT_W-1:0]  cnt_q;
  logic [crmr_pkg::DATA_W-1:0] data_q;

  // per source slot state
  logic [crmr_pkg::ID_W-1:0]  slot_id_q  [crmr_pkg::SOURCES];
  logic [crmr_pkg::LEN_W-1:0] slot_len_q [crmr_pkg::SOURCES];
  logic [crmr_pkg::LEN_W-1:0] slot_rec_q [crmr_pkg::SOURCES];
  logic [crmr_pkg::SOURCES-1:0] slot_act_q;
  // sources whose words are queued or being read out
  logic [crmr_pkg::SOURCES-1:0] lock_q;

  logic [crmr_pkg::SRC_W-1:0]  src;
  logic [crmr_pkg::ID_W-1:0]   msg;
  logic                        in_range;
  logic                        can_go;
  logic                        proc;
  logic                        first;
  logic [crmr_pkg::LEFT_W-1:0] left;
  logic [crmr_pkg::LEN_W-1:0]  left1;
  logic [crmr_pkg::LEN_W-1:0]  len_cur;
  logic [crmr_pkg::LEN_W-1:0]  rec_cur;
  logic                        act;
  logic [crmr_pkg::LEN_W-1:0]  idx;
  logic                        store;
  logic [crmr_pkg::LEN_W-1:0]  rec_new;
  logic                        complete;
  logic [crmr_pkg::DATA_W-1:0] masked;

  assign busy_o = held_q;

  // decode the held frame
  assign src      = fid_q[crmr_pkg::SEQ_SHIFT+crmr_pkg::SOURCE_SHIFT +: crmr_pkg::SRC_W];
  assign msg      = fid_q[crmr_pkg::SEQ_SHIFT +: crmr_pkg::ID_W];
  assign in_range = {1'b0, src} < (crmr_pkg::SRC_W+1)'(crmr_pkg::SOURCES);
  assign first    = !fid_q[crmr_pkg::FIRST_BIT];
  assign left     = ~fid_q[crmr_pkg::LEFT_W-1:0];
  assign left1    = {1'b0, left} + crmr_pkg::LEN_W'(1);

  // wait while the source is still read out or the queue has no room
  assign can_go = held_q && (!in_range || (!lock_q[src] && !q_full_i));
  assign proc   = can_go && in_range;

  // slot view after a first frame reopens it
  assign len_cur = first ? left1 : slot_len_q[src];
  assign rec_cur = first ? '0 : slot_rec_q[src];
  assign act     = first || slot_act_q[src];
  assign idx     = len_cur - left1;
  assign store   = act && (len_cur >= left1) && (idx == rec_cur) &&
                   (idx < crmr_pkg::LEN_W'(crmr_pkg::MAX_WORDS));
  assign rec_new  = rec_cur + crmr_pkg::LEN_W'(store);
  assign complete = act && (rec_new == len_cur) && (rec_new != '0);

  // clear bytes beyond the byte count
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (crmr_pkg::CNT_W'(b) < cnt_q) ? data_q[b*8 +: 8] : 8'h00;
    end
  end

  assign we_o    = proc && store;
  assign waddr_o = crmr_pkg::word_addr(src, idx[crmr_pkg::IDX_W-1:0]);
  assign wdata_o = masked;

  // completed message goes to the queue
  assign push_o.valid      = proc && complete;
  assign push_o.job.src    = src;
  assign push_o.job.msg_id = first ? msg : slot_id_q[src];
  assign push_o.job.len    = len_cur;

  // frame holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (start_i && !held_q) begin
      held_q <= 1'b1;
    end else if (can_go) begin
      held_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !held_q) begin
      fid_q  <= frame_id_i;
      cnt_q  <= byte_count_i;
      data_q <= frame_data_i;
    end
  end

  // slot table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < crmr_pkg::SOURCES; s++) begin
        slot_id_q[s]  <= '0;
        slot_len_q[s] <= '0;
        slot_rec_q[s] <= '0;
      end
      slot_act_q <= '0;
    end else if (proc) begin
      if (first) begin
        slot_id_q[src] <= msg;
      end
      slot_rec_q[src] <= act ? rec_new : slot_rec_q[src];
      if (complete) begin
        slot_act_q[src] <= 1'b0;
        slot_len_q[src] <= '0;
      end else begin
        slot_act_q[src] <= act;
        slot_len_q[src] <= len_cur;
      end
    end
  end

  // read-out locks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= '0;
    end else begin
      if (release_i.valid) begin
        lock_q[release_i.src] <= 1'b0;
      end
      if (push_o.valid) begin
        lock_q[src] <= 1'b1;
      end
    end
  end

endmodule

/* sv/crmr_queue.sv */
module crmr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crmr_pkg::push_t push_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output crmr_pkg::job_t  head_o
);

  crmr_pkg::job_t mem_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  // two entry job queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

endmodule

/* sv/crmr_back.sv */
module crmr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  crmr_pkg::job_t                head_i,
  output logic                          pop_o,
  output crmr_pkg::release_t            release_o,
  output logic                          re_o,
  output logic [crmr_pkg::ADDR_W-1:0]   raddr_o,
  input  logic [crmr_pkg::DATA_W-1:0]   rdata_i,
  output logic                          result_valid_o,
  output logic [crmr_pkg::ID_W-1:0]     message_id_o,
  output logic [crmr_pkg::WORDS_W-1:0]  message_words_o,
  output logic [crmr_pkg::IDX_W-1:0]    word_index_o,
  output logic [crmr_pkg::DATA_W-1:0]   payload_word_o,
  output logic                          last_word_o
);

  logic                       active_q;
  logic [crmr_pkg::IDX_W-1:0] k_q;
  crmr_pkg::job_t             job_q;
  logic                       last_issue;

  // output stage, aligned with the registered read data
  logic                       p_valid_q;
  logic [crmr_pkg::IDX_W-1:0] p_idx_q;
  logic                       p_last_q;
  logic [crmr_pkg::ID_W-1:0]  p_id_q;
  logic [crmr_pkg::LEN_W-1:0] p_len_q;

  assign last_issue = (crmr_pkg::LEN_W'(k_q) + crmr_pkg::LEN_W'(1)) == job_q.len;
  assign pop_o      = !active_q && !empty_i;

  // one word read per cycle
  assign re_o    = active_q;
  assign raddr_o = crmr_pkg::word_addr(job_q.src, k_q);

  // source may take new frames once its last word is read
  assign release_o.valid = active_q && last_issue;
  assign release_o.src   = job_q.src;

  // read-out sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      k_q      <= '0;
    end else if (active_q) begin
      active_q <= !last_issue;
      k_q      <= k_q + crmr_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q  <= k_q;
    p_last_q <= last_issue;
    p_id_q   <= job_q.msg_id;
    p_len_q  <= job_q.len;
  end

  assign result_valid_o  = p_valid_q;
  assign message_id_o    = p_id_q;
  assign message_words_o = p_len_q[crmr_pkg::WORDS_W-1:0];
  assign word_index_o    = p_idx_q;
  assign payload_word_o  = rdata_i;
  assign last_word_o     = p_last_q;

endmodule

/* sv/can_message_reassembler.sv */
// Reassembles multi-frame messages from 29-bit extended CAN frames, one slot per
// source. A frame is taken when start_i is high and busy_o is low; it is held in
// the frame register for the slot update and then busy_o drops. busy_o stays
// high longer only while the frame's source still has a finished message being
// read out, or the two-entry job queue between the slot logic and the read-out
// is full. A frame that completes a message causes one result per word, on
// consecutive cycles once the read-out takes the message from the queue, paced
// by the single read port of the payload memory. Results appear for exactly one
// cycle with result_valid_o and cannot be held off. Payload words that were
// never written are not cleared after reset, so no clearing pass is needed.
module can_message_reassembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [crmr_pkg::FID_W-1:0]    frame_id_i,
  input  logic [crmr_pkg::CNT_W-1:0]    byte_count_i,
  input  logic [crmr_pkg::DATA_W-1:0]   frame_data_i,
  output logic                          result_valid_o,
  output logic [crmr_pkg::ID_W-1:0]     message_id_o,
  output logic [crmr_pkg::WORDS_W-1:0]  message_words_o,
  output logic [crmr_pkg::IDX_W-1:0]    word_index_o,
  output logic [crmr_pkg::DATA_W-1:0]   payload_word_o,
  output logic                          last_word_o
);

  crmr_pkg::push_t             push;
  crmr_pkg::release_t          rel;
  crmr_pkg::job_t              head;
  logic                        q_full;
  logic                        q_empty;
  logic                        pop;
  logic                        we;
  logic [crmr_pkg::ADDR_W-1:0] waddr;
  logic [crmr_pkg::DATA_W-1:0] wdata;
  logic                        re;
  logic [crmr_pkg::ADDR_W-1:0] raddr;
  logic [crmr_pkg::DATA_W-1:0] rdata;

  // slot logic and payload writes
  crmr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .frame_id_i   (frame_id_i),
    .byte_count_i (byte_count_i),
    .frame_data_i (frame_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .release_i    (rel),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  // completed messages waiting for read-out
  crmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // payload store
  crmr_ram #(
    .WIDTH (crmr_pkg::DATA_W),
    .DEPTH (crmr_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // word read-out
  crmr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .head_i          (head),
    .pop_o           (pop),
    .release_o       (rel),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .result_valid_o  (result_valid_o),
    .message_id_o    (message_id_o),
    .message_words_o (message_words_o),
    .word_index_o    (word_index_o),
    .payload_word_o  (payload_word_o),
    .last_word_o     (last_word_o)
  );

  // no job is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_full)
    else $error("job pushed into full queue");

  // last word sits at the end of the message
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_word_o) |->
      (crmr_pkg::WORDS_W'(word_index_o) + crmr_pkg::WORDS_W'(1) == message_words_o))
    else $error("last word at wrong index");

  // words of one message follow on back to back cycles
  a_word_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_word_o) |=>
      (result_valid_o && word_index_o == $past(word_index_o) + crmr_pkg::IDX_W'(1)))
    else $error("word sequence broken");

endmodule
